>>> rtl/qnu_pkg.sv
// Shared types and constants of the quaternion normalize unit.
package qnu_pkg;

   localparam int CompW  = 32;                  // component and result field width
   localparam int NumComp = 4;                  // x, y, z, w
   localparam int NumLane = 5;                  // four unit lanes and one norm lane
   localparam int SqrtLane = 4;                 // lane that forms the norm
   localparam int SqW    = 2 * CompW;           // one square
   localparam int SumW   = SqW + 1;             // sum of four squares
   localparam int RemW   = 128;                 // remainder of the bit search
   localparam int AccW   = SumW + CompW;        // root times multiplicand
   localparam int TrialW = RemW + 1;
   localparam int ResShift = 62;                // c^2 scaled by 2^62
   localparam logic [CompW-1:0] OneQ30  = CompW'(32'h4000_0000);
   localparam logic [CompW-1:0] MagMax  = '1;

   typedef struct packed {
      logic [RemW-1:0]  rem;
      logic [AccW-1:0]  acc;
      logic [CompW-1:0] root;
   } lane_type;

   typedef struct packed {
      logic                       valid;
      logic [NumComp-1:0]         neg;
      logic                       zero;
      logic                       big;
      logic [SumW-1:0]            sum;
      lane_type [NumLane-1:0]     lane;
   } row_type;

endpackage

>>> rtl/qnu_front.sv
// Front end: component magnitudes, squares, sum of squares and row setup.
module qnu_front import qnu_pkg::*; #(
   parameter int COMP_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [CompW-1:0]  in_x,
   input  logic [CompW-1:0]  in_y,
   input  logic [CompW-1:0]  in_z,
   input  logic [CompW-1:0]  in_w,
   output row_type           row_out
);

   localparam int ExtShift = CompW - COMP_WIDTH;

   logic [CompW-1:0]   raw [NumComp];
   logic [CompW-1:0]   mag_in [NumComp];
   logic [NumComp-1:0] neg_in;

   logic [CompW-1:0]   mag_ff [NumComp];
   logic [NumComp-1:0] neg_a_ff;
   logic               valid_a_ff;

   logic [SqW-1:0]     sq_ff [NumComp];
   logic [NumComp-1:0] neg_b_ff;
   logic               valid_b_ff;

   logic [SumW-1:0]    sum_in;
   row_type            row_in;
   row_type            row_ff;

   assign raw[0] = in_x;
   assign raw[1] = in_y;
   assign raw[2] = in_z;
   assign raw[3] = in_w;

   // sign-extend from the top used bit, then take sign and magnitude
   always_comb begin
      logic signed [CompW-1:0] ext;
      for (int i = 0; i < NumComp; i++) begin
         ext = $signed(raw[i] << ExtShift) >>> ExtShift;
         neg_in[i] = ext[CompW-1];
         mag_in[i] = neg_in[i] ? CompW'(-ext) : CompW'(ext);
      end
   end

   // stage A: magnitudes
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (adv) begin
         valid_a_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff   <= mag_in;
         neg_a_ff <= neg_in;
      end
   end

   // stage B: squares
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else if (adv) begin
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NumComp; i++) begin
            sq_ff[i] <= SqW'(mag_ff[i]) * SqW'(mag_ff[i]);
         end
         neg_b_ff <= neg_a_ff;
      end
   end

   // stage C: sum and seed the bit-search lanes
   assign sum_in = SumW'(sq_ff[0]) + SumW'(sq_ff[1]) + SumW'(sq_ff[2]) + SumW'(sq_ff[3]);

   always_comb begin
      row_in.valid = valid_b_ff;
      row_in.neg   = neg_b_ff;
      row_in.sum   = sum_in;
      row_in.zero  = (sum_in == '0);
      row_in.big   = sum_in[SumW-1];
      for (int i = 0; i < NumComp; i++) begin
         row_in.lane[i].rem  = RemW'(sq_ff[i]) << ResShift;
         row_in.lane[i].acc  = '0;
         row_in.lane[i].root = '0;
      end
      row_in.lane[SqrtLane].rem  = RemW'(sum_in[SqW-1:0]);
      row_in.lane[SqrtLane].acc  = '0;
      row_in.lane[SqrtLane].root = '0;
   end

   // clear the valid bit on reset, advance the row otherwise
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff.valid <= 1'b0;
      end else if (adv) begin
         row_ff.valid <= row_in.valid;
      end
      if (adv) begin
         row_ff.neg  <= row_in.neg;
         row_ff.zero <= row_in.zero;
         row_ff.big  <= row_in.big;
         row_ff.sum  <= row_in.sum;
         row_ff.lane <= row_in.lane;
      end
   end

   assign row_out = row_ff;

endmodule

>>> rtl/qnu_cell.sv
// One cell of the bit-search chain: decides one root bit in every lane.
module qnu_cell import qnu_pkg::*; #(
   parameter int BIT = 31
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    adv,
   input  row_type row_in,
   output row_type row_out
);

   row_type row_nx;
   row_type row_ff;

   // try setting this bit: trial = t*M*2^(BIT+1) + M*2^(2*BIT)
   always_comb begin
      logic [SumW-1:0]   mult;
      logic [TrialW-1:0] trial;
      row_nx = row_in;
      for (int j = 0; j < NumLane; j++) begin
         mult  = (j == SqrtLane) ? SumW'(1) : row_in.sum;
         trial = (TrialW'(row_in.lane[j].acc) << (BIT + 1))
               + (TrialW'(mult) << (2 * BIT));
         if (trial <= TrialW'(row_in.lane[j].rem)) begin
            row_nx.lane[j].rem  = row_in.lane[j].rem - trial[RemW-1:0];
            row_nx.lane[j].acc  = row_in.lane[j].acc + (AccW'(mult) << BIT);
            row_nx.lane[j].root = row_in.lane[j].root | (CompW'(1) << BIT);
         end
      end
   end

   // clear the valid bit on reset, advance the row otherwise
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff.valid <= 1'b0;
      end else if (adv) begin
         row_ff.valid <= row_nx.valid;
      end
      if (adv) begin
         row_ff.neg  <= row_nx.neg;
         row_ff.zero <= row_nx.zero;
         row_ff.big  <= row_nx.big;
         row_ff.sum  <= row_nx.sum;
         row_ff.lane <= row_nx.lane;
      end
   end

   assign row_out = row_ff;

endmodule

>>> rtl/qnu_finish.sv
// Back end: rounding, sign, saturation and the zero case, into the output register.
module qnu_finish import qnu_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  row_type                  row_in,
   output logic                     out_valid,
   output logic signed [CompW-1:0]  out_unit [NumComp],
   output logic [CompW-1:0]         out_mag,
   output logic                     out_zero
);

   logic                    valid_ff;
   logic signed [CompW-1:0] unit_in [NumComp];
   logic signed [CompW-1:0] unit_ff [NumComp];
   logic [CompW-1:0]        mag_in;
   logic [CompW-1:0]        mag_ff;
   logic                    zero_ff;

   // halve the doubled quotient with rounding, then apply the sign
   always_comb begin
      logic [CompW:0]   half;
      logic [CompW-1:0] m;
      for (int i = 0; i < NumComp; i++) begin
         half = ({1'b0, row_in.lane[i].root} + (CompW+1)'(1)) >> 1;
         m    = half[CompW-1:0];
         unit_in[i] = row_in.neg[i] ? $signed(CompW'(-m)) : $signed(m);
      end
      if (row_in.zero) begin
         for (int i = 0; i < NumComp; i++) begin
            unit_in[i] = '0;
         end
         unit_in[NumComp-1] = $signed(OneQ30);
      end
   end

   // round the norm to nearest and saturate; a zero input gives zero
   always_comb begin
      logic [CompW-1:0] r;
      r = row_in.lane[SqrtLane].root;
      if (row_in.zero) begin
         mag_in = '0;
      end else if (row_in.big) begin
         mag_in = MagMax;
      end else if (row_in.lane[SqrtLane].rem > RemW'(r)) begin
         mag_in = (r == MagMax) ? MagMax : r + CompW'(1);
      end else begin
         mag_in = r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= row_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         unit_ff <= unit_in;
         mag_ff  <= mag_in;
         zero_ff <= row_in.zero;
      end
   end

   assign out_valid = valid_ff;
   assign out_unit  = unit_ff;
   assign out_mag   = mag_ff;
   assign out_zero  = zero_ff;

endmodule

>>> rtl/quaternion_normalize_unit.sv
// Top level of the quaternion normalize unit: front end, bit-search chain, back end.
//
//   channel | ports                                        | direction
//   req     | req_valid/ready, req_in_x..req_in_w          | in
//   rsp     | rsp_valid/ready, rsp_unit_*, rsp_magnitude,  | out
//           | rsp_was_zero                                 |
//
// One quaternion per cycle is taken while the result is not stalled. The pipeline
// holds three front stages (magnitude, square, sum), 32 chain cells that each settle
// one root bit in all five lanes, and the output register.
// Synchronous reset clears only the valid bits of the pipeline.
// A stalled result freezes the whole pipeline; req_ready follows rsp_ready then.
module quaternion_normalize_unit import qnu_pkg::*; #(
   parameter int COMP_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [CompW-1:0]  req_in_x,
   input  logic signed [CompW-1:0]  req_in_y,
   input  logic signed [CompW-1:0]  req_in_z,
   input  logic signed [CompW-1:0]  req_in_w,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [CompW-1:0]  rsp_unit_x,
   output logic signed [CompW-1:0]  rsp_unit_y,
   output logic signed [CompW-1:0]  rsp_unit_z,
   output logic signed [CompW-1:0]  rsp_unit_w,
   output logic [CompW-1:0]         rsp_magnitude,
   output logic                     rsp_was_zero
);

   logic                    adv;
   row_type                 chain [CompW+1];
   logic signed [CompW-1:0] unit [NumComp];

   // advance whenever the output register is empty or being drained
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   qnu_front #(.COMP_WIDTH(COMP_WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .in_x     (req_in_x),
      .in_y     (req_in_y),
      .in_z     (req_in_z),
      .in_w     (req_in_w),
      .row_out  (chain[0])
   );

   // most significant root bit first
   for (genvar k = 0; k < CompW; k++) begin : g_cell
      qnu_cell #(.BIT(CompW - 1 - k)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .row_in  (chain[k]),
         .row_out (chain[k+1])
      );
   end

   qnu_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .row_in    (chain[CompW]),
      .out_valid (rsp_valid),
      .out_unit  (unit),
      .out_mag   (rsp_magnitude),
      .out_zero  (rsp_was_zero)
   );

   assign rsp_unit_x = unit[0];
   assign rsp_unit_y = unit[1];
   assign rsp_unit_z = unit[2];
   assign rsp_unit_w = unit[3];

endmodule

>>> tb/quaternion_normalize_unit_test.sv
// Self-checking testbench for the quaternion normalize unit.
module quaternion_normalize_unit_test;
   import qnu_pkg::*;

   typedef struct {
      logic signed [CompW-1:0] unit_x;
      logic signed [CompW-1:0] unit_y;
      logic signed [CompW-1:0] unit_z;
      logic signed [CompW-1:0] unit_w;
      logic [CompW-1:0]        magnitude;
      logic                    was_zero;
   } unit_quat_type;

   localparam logic [CompW-1:0] MostNeg = 32'h8000_0000;
   localparam logic [CompW-1:0] MostPos = 32'h7FFF_FFFF;
   localparam logic [CompW-1:0] OneQ16  = 32'h0001_0000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [CompW-1:0] req_in_x, req_in_y, req_in_z, req_in_w;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [CompW-1:0] rsp_unit_x, rsp_unit_y, rsp_unit_z, rsp_unit_w;
   logic [CompW-1:0] rsp_magnitude;
   logic rsp_was_zero;

   unit_quat_type pending_units[$];
   int unsigned mismatches = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;

   quaternion_normalize_unit DUT (.*);

   // clock generation
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // bound the run
   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // exact normalization: norm rounded to nearest, components by bit search
   function automatic unit_quat_type normalize_quat(logic [CompW-1:0] x, logic [CompW-1:0] y,
                                                    logic [CompW-1:0] z, logic [CompW-1:0] w);
      unit_quat_type res;
      logic [CompW-1:0] comp[4];
      logic [CompW-1:0] absv[4];
      logic neg[4];
      logic [64:0] sum_sq;
      logic [32:0] root, cand;
      logic [191:0] lhs, rhs;
      logic [31:0] m, mcand, step;
      logic [31:0] units[4];
      comp[0] = x; comp[1] = y; comp[2] = z; comp[3] = w;
      sum_sq = '0;
      for (int i = 0; i < 4; i++) begin
         neg[i] = comp[i][CompW-1];
         absv[i] = neg[i] ? (~comp[i] + 1'b1) : comp[i];
         sum_sq = sum_sq + 65'(absv[i]) * 65'(absv[i]);
      end
      if (sum_sq == '0) begin
         res.unit_x = '0; res.unit_y = '0; res.unit_z = '0; res.unit_w = OneQ30;
         res.magnitude = '0; res.was_zero = 1'b1;
         return res;
      end
      // floor square root, then round to nearest
      root = '0;
      for (int b = 32; b >= 0; b--) begin
         cand = root | (33'd1 << b);
         if (192'(cand) * 192'(cand) <= 192'(sum_sq)) root = cand;
      end
      if (192'(sum_sq) - 192'(root) * 192'(root) > 192'(root)) root = root + 1'b1;
      res.magnitude = root[32] ? MagMax : root[31:0];
      // largest m with (2m-1)^2 * S <= c^2 * 2^62
      for (int i = 0; i < 4; i++) begin
         m = '0;
         rhs = (192'(absv[i]) * 192'(absv[i])) << ResShift;
         for (step = 32'(OneQ30); step != 0; step = step >> 1) begin
            mcand = m + step;
            if (mcand <= 32'(OneQ30)) begin
               lhs = 192'(2 * 64'(mcand) - 1);
               lhs = lhs * lhs * 192'(sum_sq);
               if (lhs <= rhs) m = mcand;
            end
         end
         units[i] = neg[i] ? (~m + 1'b1) : m;
      end
      res.unit_x = units[0]; res.unit_y = units[1];
      res.unit_z = units[2]; res.unit_w = units[3];
      res.was_zero = 1'b0;
      return res;
   endfunction

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      unit_quat_type exp_u;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_units.size() == 0) begin
            $error("unexpected result transaction");
            mismatches++;
         end else begin
            exp_u = pending_units.pop_front();
            if (rsp_unit_x !== exp_u.unit_x) begin
               $error("unit_x expected %h actual %h", exp_u.unit_x, rsp_unit_x);
               mismatches++;
            end
            if (rsp_unit_y !== exp_u.unit_y) begin
               $error("unit_y expected %h actual %h", exp_u.unit_y, rsp_unit_y);
               mismatches++;
            end
            if (rsp_unit_z !== exp_u.unit_z) begin
               $error("unit_z expected %h actual %h", exp_u.unit_z, rsp_unit_z);
               mismatches++;
            end
            if (rsp_unit_w !== exp_u.unit_w) begin
               $error("unit_w expected %h actual %h", exp_u.unit_w, rsp_unit_w);
               mismatches++;
            end
            if (rsp_magnitude !== exp_u.magnitude) begin
               $error("magnitude expected %h actual %h", exp_u.magnitude, rsp_magnitude);
               mismatches++;
            end
            if (rsp_was_zero !== exp_u.was_zero) begin
               $error("was_zero expected %b actual %b", exp_u.was_zero, rsp_was_zero);
               mismatches++;
            end
         end
      end
   end

   // send one quaternion and record its expected result on acceptance
   task automatic send_quat(logic [CompW-1:0] x, logic [CompW-1:0] y,
                            logic [CompW-1:0] z, logic [CompW-1:0] w);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_in_x <= x; req_in_y <= y; req_in_z <= z; req_in_w <= w;
      do @(posedge clock); while (!req_ready);
      pending_units.push_back(normalize_quat(x, y, z, w));
   endtask

   // hold the sender until every expected result has come
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_units.size() != 0) @(posedge clock);
   endtask

   // random component: full range, small of either sign, zero, or the most negative or positive value
   function automatic logic [CompW-1:0] rand_comp();
      logic [CompW-1:0] v;
      case ($urandom_range(5))
         0, 1: v = $urandom;
         2: v = $urandom >> $urandom_range(31);
         3: v = -($urandom >> $urandom_range(31));
         4: v = '0;
         default: v = ($urandom_range(1) != 0) ? MostNeg : MostPos;
      endcase
      return v;
   endfunction

   task automatic test_directed();
      send_quat('0, '0, '0, '0);
      send_quat(MostNeg, MostNeg, MostNeg, MostNeg);
      send_quat(MostPos, MostPos, MostPos, MostPos);
      send_quat(MostNeg, '0, '0, '0);
      send_quat('0, MostPos, '0, '0);
      send_quat('0, '0, 32'd1, '0);
      send_quat('0, '0, '0, 32'hFFFF_FFFF);
      send_quat(OneQ16, OneQ16, OneQ16, OneQ16);
      send_quat(-OneQ16, OneQ16, -OneQ16, OneQ16);
      send_quat(32'd3, 32'd4, '0, '0);
      send_quat(32'd1, 32'd1, 32'd1, '0);
      send_quat(32'd1, 32'd2, 32'd2, '0);
      send_quat(MostNeg, MostPos, 32'd1, 32'hFFFF_FFFF);
      send_quat(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
      send_quat('0, '0, '0, OneQ16);
      drain_results();
   endtask

   task automatic test_random(int unsigned count, int unsigned idle_pct,
                              int unsigned stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      end
      drain_results();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_x = '0; req_in_y = '0; req_in_z = '0; req_in_w = '0;
      rsp_ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(700, 0, 0);
      test_random(400, 87, 0);
      test_random(400, 0, 87);
      test_random(400, 20, 20);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending_units.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> sim.f
rtl/qnu_pkg.sv
rtl/qnu_front.sv
rtl/qnu_cell.sv
rtl/qnu_finish.sv
rtl/quaternion_normalize_unit.sv
tb/quaternion_normalize_unit_test.sv
